>>> rtl/ray_box_slab_intersect_defines.svh
// Assertion macros used by ray_box_slab_intersect.sv.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define RBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RBS_ASSERT_NOW(label, clk, rst, ante, cons)
`define RBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rbs_pkg.sv
package rbs_pkg;

  // Internal distances are signed with a magnitude of at most 2^62-1.
  localparam int TW = 63;
  localparam logic [61:0] T_MAG_MAX = {62{1'b1}};
  localparam logic signed [TW-1:0] DIST_MAX = TW'(64'h7FFF_FFFF);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [TW-1:0] dist_t;

  // Per-ray flags that ride along the divider pipeline.
  typedef struct packed {
    logic [2:0] neg_lo;   // sign of the quotient for the minus-half plane
    logic [2:0] neg_hi;   // sign of the quotient for the plus-half plane
    logic [2:0] dzero;    // direction component is zero
    logic       outside;  // a parallel axis has the origin outside its slab
  } side_t;

  // Running entry/exit interval.
  typedef struct packed {
    logic       any;
    dist_t      t_near;
    dist_t      t_far;
    logic [1:0] n_axis;
    logic       n_pos;
  } fold_t;

  // Folds one axis into the interval; earlier axes win ties on the entry.
  function automatic fold_t fold_axis(fold_t f, logic dz, logic [1:0] ax, logic pos,
                                      dist_t t1, dist_t t2);
    fold_t r;
    r = f;
    if (!dz) begin
      if (!f.any || (t1 > f.t_near)) begin
        r.t_near = t1;
        r.n_axis = ax;
        r.n_pos  = pos;
      end
      if (!f.any || (t2 < f.t_far)) begin
        r.t_far = t2;
      end
      r.any = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/ray_box_slab_intersect.sv
// Channel        Direction  Payload (lowest bit first)
// s_axis (ray)   in         origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// m_axis (hit)   out        hit, distance, normal_axis, normal_positive
// cfg_wr         in         hit_epsilon (16 bits)
//
// One transaction enters per cycle while the output is not stalled.
// The six restoring dividers produce one quotient bit per stage.
// Reset (rst, synchronous) clears every stage valid bit and sets hit_epsilon to 1.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
`include "ray_box_slab_intersect_defines.svh"

module ray_box_slab_intersect import rbs_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad to whole bytes
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // hit [0], distance [31:1], normal_axis [33:32], normal_positive [34], pad
  output logic [39:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = COORD_WIDTH + FRAC_BITS;   // quotient width
  localparam int MW = (QW > 62) ? QW : 62;
  localparam int NL = 6;                         // divider lanes: 2 per axis

  // The hit epsilon register.
  logic [15:0] hit_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_epsilon <= 16'd1;
    end else if (cfg_wr_en) begin
      hit_epsilon <= cfg_wr_data;
    end
  end

  // The whole pipeline advances together whenever the output register can move.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------------------------------------------------------------------
  // Front end: plane offsets, magnitudes and signs.
  // ---------------------------------------------------------------------------
  localparam logic signed [CW:0] HALF = (CW+1)'(1) <<< (FRAC_BITS - 1);

  logic [CW-1:0] f_num [NL];
  logic [CW-1:0] f_den [NL];
  side_t         f_side;

  always_comb begin
    logic signed [CW-1:0] o;
    logic signed [CW-1:0] d;
    logic signed [CW:0]   oe;
    logic signed [CW:0]   de;
    logic signed [CW:0]   nlo;
    logic signed [CW:0]   nhi;
    logic [CW:0]          dabs;
    logic [CW:0]          lo_abs;
    logic [CW:0]          hi_abs;
    f_side = '0;
    for (int ax = 0; ax < 3; ax++) begin
      o   = s_tdata[ax*CW +: CW];
      d   = s_tdata[(ax+3)*CW +: CW];
      oe  = (CW+1)'(o);
      de  = (CW+1)'(d);
      nlo = -HALF - oe;
      nhi = HALF - oe;
      dabs   = de[CW] ? -de : de;
      lo_abs = nlo[CW] ? -nlo : nlo;
      hi_abs = nhi[CW] ? -nhi : nhi;
      f_num[2*ax]     = lo_abs[CW-1:0];
      f_num[2*ax + 1] = hi_abs[CW-1:0];
      f_den[2*ax]     = dabs[CW-1:0];
      f_den[2*ax + 1] = dabs[CW-1:0];
      f_side.neg_lo[ax] = nlo[CW] ^ de[CW];
      f_side.neg_hi[ax] = nhi[CW] ^ de[CW];
      f_side.dzero[ax]  = (d == '0);
      if ((d == '0) && ((oe < -HALF) || (oe > HALF))) begin
        f_side.outside = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline: stage s holds the partial remainder and the dividend bits
  // still to be consumed, with quotient bits shifted in from the bottom.
  // ---------------------------------------------------------------------------
  logic          dv   [QW+1];
  logic [CW-1:0] drem [QW+1][NL];
  logic [QW-1:0] dnq  [QW+1][NL];
  logic [CW-1:0] dden [QW+1][NL];
  side_t         dside [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= f_side;
      for (int l = 0; l < NL; l++) begin
        drem[0][l] <= '0;
        dnq[0][l]  <= {f_num[l], {FRAC_BITS{1'b0}}};
        dden[0][l] <= f_den[l];
      end
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [CW:0] r2;
      logic        ge;
      logic [CW:0] rdiff;
      assign r2    = {drem[s][l], dnq[s][l][QW-1]};
      assign ge    = (r2 >= {1'b0, dden[s][l]});
      assign rdiff = r2 - {1'b0, dden[s][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          drem[s+1][l] <= ge ? rdiff[CW-1:0] : r2[CW-1:0];
          dnq[s+1][l]  <= {dnq[s][l][QW-2:0], ge};
          dden[s+1][l] <= dden[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[s+1] <= dside[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: saturate each quotient and apply its sign.
  // ---------------------------------------------------------------------------
  logic  a_v;
  dist_t a_t [NL];
  side_t a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    logic [MW-1:0] mx;
    logic [61:0]   mag;
    logic          ng;
    if (en) begin
      a_side <= dside[QW];
      for (int l = 0; l < NL; l++) begin
        mx  = MW'(dnq[QW][l]);
        mag = (mx > MW'(T_MAG_MAX)) ? T_MAG_MAX : mx[61:0];
        ng  = l[0] ? dside[QW].neg_hi[l/2] : dside[QW].neg_lo[l/2];
        a_t[l] <= ng ? -dist_t'({1'b0, mag}) : dist_t'({1'b0, mag});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: order the two plane distances of each axis.
  // ---------------------------------------------------------------------------
  logic       b_v;
  dist_t      b_lo [3];
  dist_t      b_hi [3];
  logic [2:0] b_pos;
  side_t      b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      for (int ax = 0; ax < 3; ax++) begin
        // Equal distances keep their order and a minus-facing normal.
        if (a_t[2*ax] > a_t[2*ax + 1]) begin
          b_lo[ax]  <= a_t[2*ax + 1];
          b_hi[ax]  <= a_t[2*ax];
          b_pos[ax] <= 1'b1;
        end else begin
          b_lo[ax]  <= a_t[2*ax];
          b_hi[ax]  <= a_t[2*ax + 1];
          b_pos[ax] <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: fold the x and y slabs. Stage D: fold z and decide the hit.
  // ---------------------------------------------------------------------------
  logic  c_v;
  fold_t c_fold;
  dist_t c_lo;
  dist_t c_hi;
  logic  c_pos;
  logic  c_dz;
  logic  c_outside;

  fold_t c_fold_next;
  always_comb begin
    c_fold_next = fold_axis('0, b_side.dzero[0], AXIS_X, b_pos[0], b_lo[0], b_hi[0]);
    c_fold_next = fold_axis(c_fold_next, b_side.dzero[1], AXIS_Y, b_pos[1], b_lo[1], b_hi[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_fold    <= c_fold_next;
      c_lo      <= b_lo[2];
      c_hi      <= b_hi[2];
      c_pos     <= b_pos[2];
      c_dz      <= b_side.dzero[2];
      c_outside <= b_side.outside;
    end
  end

  dist_t eps_t;
  assign eps_t = dist_t'({1'b0, hit_epsilon});

  logic  d_v;
  fold_t d_fold;
  logic  d_hit;

  fold_t d_fold_next;
  always_comb begin
    d_fold_next = fold_axis(c_fold, c_dz, AXIS_Z, c_pos, c_lo, c_hi);
  end

  // Checking the interval once at the end is the same as after every axis:
  // the entry only grows and the exit only shrinks.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_fold <= d_fold_next;
      d_hit  <= d_fold_next.any && !c_outside &&
                !(d_fold_next.t_near > d_fold_next.t_far) &&
                !(d_fold_next.t_far <= eps_t);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E (output register): pick and clamp the reported distance.
  // ---------------------------------------------------------------------------
  dist_t e_t;
  dist_t e_clamp;
  always_comb begin
    // An entry behind the epsilon means the origin is inside: report the exit.
    e_t     = (d_fold.t_near < eps_t) ? d_fold.t_far : d_fold.t_near;
    e_clamp = e_t;
    if (e_t < 0) begin
      e_clamp = '0;
    end
    if (e_t > DIST_MAX) begin
      e_clamp = DIST_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_hit) begin
        m_tdata <= {5'b0, d_fold.n_pos, d_fold.n_axis, e_clamp[30:0], 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  `RBS_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[34:1] == '0)
  `RBS_ASSERT_NOW(a_axis_code, clk, rst, m_tvalid, m_tdata[33:32] != 2'd3)
  `RBS_ASSERT_NOW(a_stall_blocks, clk, rst, m_tvalid && !m_tready, !s_tready)
  `RBS_ASSERT_NEXT(a_enter, clk, rst, s_tvalid && s_tready, dv[0])

endmodule

>>> sim/ray_box_slab_checker.sv
module ray_box_slab_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic [191:0] s_tdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [39:0]  m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [1:0]  normal_axis;
    logic        normal_positive;
  } hit_rec_t;

  localparam longint HALF = 64'sd32768;
  localparam longint SAT_MAG = (64'sd1 <<< 62) - 1;
  localparam longint DIST_LIMIT = 64'sh7FFF_FFFF;

  logic [15:0] epsilon;
  hit_rec_t expected_hits[$];

  // Plane distance num * 2^16 / den, truncated toward zero on magnitudes.
  function automatic longint plane_dist(longint num, longint den);
    logic neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if ((un / ud) >= (64'd1 << 46)) q = SAT_MAG;
    else q = (un << 16) / ud;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_rec_t trace_ray(logic [191:0] ray, logic [15:0] eps_val);
    hit_rec_t r;
    longint o, d, t1, t2, t_near, t_far, eps, t;
    logic any, hit, pos, n_pos;
    logic [1:0] n_axis;
    eps = eps_val;
    any = 0; hit = 1; n_pos = 0; n_axis = 0; t_near = 0; t_far = 0;
    for (int ax = 0; ax < 3; ax++) begin
      if (hit) begin
        o = longint'($signed(ray[32*ax +: 32]));
        d = longint'($signed(ray[32*(ax+3) +: 32]));
        if (d == 0) begin
          if (o < -HALF || o > HALF) hit = 0;
        end else begin
          t1 = plane_dist(-HALF - o, d);
          t2 = plane_dist(HALF - o, d);
          pos = 0;
          if (t1 > t2) begin
            t = t1; t1 = t2; t2 = t; pos = 1;
          end
          if (!any || t1 > t_near) begin
            t_near = t1; n_axis = ax[1:0]; n_pos = pos;
          end
          if (!any || t2 < t_far) t_far = t2;
          any = 1;
          if (t_near > t_far || t_far <= eps) hit = 0;
        end
      end
    end
    r = '0;
    if (any && hit) begin
      t = (t_near < eps) ? t_far : t_near;
      if (t < 0) t = 0;
      if (t > DIST_LIMIT) t = DIST_LIMIT;
      r.hit = 1;
      r.distance = t[30:0];
      r.normal_axis = n_axis;
      r.normal_positive = n_pos;
    end
    return r;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_rec_t got, want;
    if (rst) begin
      epsilon <= 16'd1;
      errors <= 0;
    end else begin
      if (cfg_wr_en) epsilon <= cfg_wr_data;
      if (s_tvalid && s_tready) expected_hits.push_back(trace_ray(s_tdata, epsilon));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[34], m_tdata[33:32], m_tdata[31:1], m_tdata[0]} == 0 ? '0 : '0;
        got.hit = m_tdata[0];
        got.distance = m_tdata[31:1];
        got.normal_axis = m_tdata[33:32];
        got.normal_positive = m_tdata[34];
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_hits.pop_front();
          if (got.hit != want.hit || got.distance != want.distance ||
              got.normal_axis != want.normal_axis ||
              got.normal_positive != want.normal_positive) begin
            $display("%0t: mismatch expected hit=%0d dist=%h axis=%0d pos=%0d",
                     $time, want.hit, want.distance, want.normal_axis,
                     want.normal_positive);
            $display("%0t:          actual   hit=%0d dist=%h axis=%0d pos=%0d",
                     $time, got.hit, got.distance, got.normal_axis,
                     got.normal_positive);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_ray_box_slab_intersect.sv
module tb_ray_box_slab_intersect;
  import rbs_pkg::*;

  // One unit in Q15.16.
  localparam int ONE = 65536;
  // Pipeline depth is COORD_WIDTH + FRAC_BITS + 6; wait a little longer.
  localparam int SETTLE = 70;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 0;
  logic         rst = 1;
  logic [191:0] s_tdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [39:0]  m_tdata;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic         cfg_wr_en = 0;
  logic [15:0]  cfg_wr_data = '0;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           stall_mode = 0;

  always #5 clk = ~clk;

  ray_box_slab_intersect uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  ray_box_slab_checker chk (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .pending(pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver switches at random between always-ready, light stalls and heavy
  // stalls, so backpressure lands on every pipeline phase.
  always @(posedge clk) begin
    if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Sends one ray transaction. Called just after a rising edge; returns just
  // after the edge at which the transaction was accepted. The valid is left
  // high when another transaction follows back to back.
  task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input bit keep);
    s_tdata <= {dz, dy, dx, oz, oy, ox};
    s_tvalid <= 1'b1;
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    if (!keep) s_tvalid <= 1'b0;
  endtask

  task automatic write_epsilon(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] small_coord(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random rays: mostly rays aimed toward a point in or near the box, mixed at
  // random with rays with zeroed components and with raw 32-bit noise.
  task automatic random_rays(input int count);
    logic [31:0] o[3], d[3];
    int kind, gap, burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        o[a] = small_coord(4 * ONE);
        if (kind < 6) d[a] = small_coord(ONE * 3 / 4) - o[a];
        else if (kind < 8) d[a] = ($urandom_range(0, 2) == 0) ? 32'd0 : small_coord(2 * ONE);
        else begin
          o[a] = $urandom();
          d[a] = $urandom();
        end
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst--;
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2], burst != 0 || gap == 0);
      if (burst == 0 && gap != 0) repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays under the reset epsilon.
    send_ray(0, 0, 0, 0, 0, 0, 1);                        // zero direction
    send_ray(2 * ONE, 0, 0, 0, 0, ONE, 1);                // parallel, outside slab
    send_ray(0, 0, -3 * ONE, 0, 0, ONE, 1);               // parallel inside, hit z
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 1);               // entry -x
    send_ray(3 * ONE, 0, 0, -ONE, 0, 0, 1);               // entry +x
    send_ray(0, -3 * ONE, 0, 0, ONE, 0, 1);               // entry -y
    send_ray(0, 3 * ONE, 0, 0, -ONE, 0, 1);               // entry +y
    send_ray(0, 0, 3 * ONE, 0, 0, -ONE, 1);               // entry +z
    send_ray(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 1);          // origin inside
    send_ray(3 * ONE, 0, 0, ONE, 0, 0, 1);                // box behind origin
    send_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE, 1); // tie across axes
    send_ray(-3 * ONE, ONE / 2, 0, ONE, 0, 0, 1);         // grazing the y face
    send_ray(-3 * ONE, 3 * ONE, 0, ONE, 0, 0, 1);         // miss beside box
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_ray(32'h8000_0000, 0, 0, 1, 0, 0, 1);            // distance saturates
    send_ray(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    send_ray(-ONE / 2 - 1, 0, 0, 1, 0, 0, 1);             // entry just outside the -x face
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    @(posedge clk);
    random_rays(200);
    wait_drained();

    // The random rays follow directly, so the valid stays high.
    write_epsilon(16'd0);
    send_ray(-ONE / 2, 0, 0, ONE, 0, 0, 1);               // origin on the -x face
    random_rays(250);
    wait_drained();

    write_epsilon(16'hFFFF);
    send_ray(0, 0, 0, ONE, 0, 0, 1);
    random_rays(250);
    wait_drained();

    write_epsilon(16'($urandom()));
    random_rays(250);
    wait_drained();

    write_epsilon(16'd1);
    random_rays(250);
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rbs_pkg.sv
rtl/ray_box_slab_intersect.sv
sim/ray_box_slab_checker.sv
sim/tb_ray_box_slab_intersect.sv
